[design/caf_pkg.sv]
// Shared types, widths and constants of the signed 2D angle force pipeline.
// No dependencies; imported by the CORDIC cell, the divider cell and the top level.
`default_nettype none
package caf_pkg;

    localparam int DEFAULT_CORDIC_STEPS = 24;

    localparam int POS_W  = 32;   // Q16.16 position / force
    localparam int DIF_W  = 33;   // bond vector component
    localparam int PROD_W = 66;   // component product
    localparam int CS_W   = 67;   // cosine / sine terms
    localparam int VIN_W  = 60;   // CORDIC input magnitude limit
    localparam int VEC_W  = 64;   // CORDIC x, y
    localparam int ANG_W  = 32;   // Q4.28 angle accumulator
    localparam int REST_W = 31;
    localparam int K_W    = 32;
    localparam int MAG_W  = 31;   // scaled bond component magnitude
    localparam int REM_W  = 63;   // divisor / remainder
    localparam int PP_W   = 63;   // partial product, 32 x 31
    localparam int NUM_W  = 83;   // scaled numerator, one divider cell per bit
    localparam int F_W    = 87;   // wide signed force before saturation
    localparam int TYPES  = 4;
    localparam int LANES  = 4;

    localparam logic signed [ANG_W-1:0] PI_Q28 = 32'sd843314857;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_SPRING0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPRING1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPRING2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPRING3 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REST0   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REST1   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REST2   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REST3   = 4'd7;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } t_vec;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quo;
        logic [REM_W-1:0] divisor;
    } t_div;

    typedef struct packed {
        logic [K_W-1:0]           k;
        logic signed [REST_W-1:0] rest;
        logic                     degen;
        logic                     tneg;
        logic                     sdx1;
        logic                     sdy1;
        logic                     sdx2;
        logic                     sdy2;
        logic [1:0]               m1;
        logic [1:0]               m2;
        logic [MAG_W-1:0]         a1;
        logic [MAG_W-1:0]         b1;
        logic [MAG_W-1:0]         a2;
        logic [MAG_W-1:0]         b2;
        logic [REM_W-1:0]         r2_1;
        logic [REM_W-1:0]         r2_2;
    } t_ctx;

    typedef struct packed {
        logic [POS_W-1:0] energy;
        logic             degen;
        logic [LANES-1:0] neg;
    } t_tail;

    typedef struct packed {
        logic signed [POS_W-1:0] fax;
        logic signed [POS_W-1:0] fay;
        logic signed [POS_W-1:0] fpx;
        logic signed [POS_W-1:0] fpy;
        logic signed [POS_W-1:0] fbx;
        logic signed [POS_W-1:0] fby;
        logic [POS_W-1:0]        energy;
        logic                    degen;
    } t_res;

    // atan(2^-i) in Q4.28
    function automatic logic signed [ANG_W-1:0] atan_q28(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:  v = 32'sd210828714;
            5'd1:  v = 32'sd124459457;
            5'd2:  v = 32'sd65760959;
            5'd3:  v = 32'sd33381290;
            5'd4:  v = 32'sd16755422;
            5'd5:  v = 32'sd8385879;
            5'd6:  v = 32'sd4193963;
            5'd7:  v = 32'sd2097109;
            5'd8:  v = 32'sd1048571;
            5'd9:  v = 32'sd524287;
            5'd10: v = 32'sd262144;
            5'd11: v = 32'sd131072;
            5'd12: v = 32'sd65536;
            5'd13: v = 32'sd32768;
            5'd14: v = 32'sd16384;
            5'd15: v = 32'sd8192;
            5'd16: v = 32'sd4096;
            5'd17: v = 32'sd2048;
            5'd18: v = 32'sd1024;
            5'd19: v = 32'sd512;
            5'd20: v = 32'sd256;
            5'd21: v = 32'sd128;
            5'd22: v = 32'sd64;
            5'd23: v = 32'sd32;
            5'd24: v = 32'sd16;
            5'd25: v = 32'sd8;
            5'd26: v = 32'sd4;
            5'd27: v = 32'sd2;
            5'd28: v = 32'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[design/caf_cordic_cell.sv]
// One vectoring CORDIC rotation, registered; a row of these forms the angle chain.
// Depends on caf_pkg.
`default_nettype none
module caf_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  caf_pkg::t_vec i_vec,
    output caf_pkg::t_vec o_vec
);
    import caf_pkg::*;

    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;
    t_vec                    n_vec;
    t_vec                    r_vec;

    always_comb begin
        xs    = i_vec.x >>> STAGE;
        ys    = i_vec.y >>> STAGE;
        n_vec = i_vec;
        // y >= 0 rotates clockwise
        if (!i_vec.y[VEC_W-1]) begin
            n_vec.x = i_vec.x + ys;
            n_vec.y = i_vec.y - xs;
            n_vec.z = i_vec.z + atan_q28(5'(STAGE));
        end else begin
            n_vec.x = i_vec.x - ys;
            n_vec.y = i_vec.y + xs;
            n_vec.z = i_vec.z - atan_q28(5'(STAGE));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule
`default_nettype wire

[design/caf_div_cell.sv]
// One restoring division step (one quotient bit), registered.
// Depends on caf_pkg.
`default_nettype none
module caf_div_cell (
    input  logic          i_clk,
    input  logic          i_en,
    input  caf_pkg::t_div i_div,
    output caf_pkg::t_div o_div
);
    import caf_pkg::*;

    logic [REM_W:0] trial;
    logic           fits;
    t_div           n_div;
    t_div           r_div;

    always_comb begin
        trial       = {i_div.rem, i_div.num[NUM_W-1]};
        fits        = trial >= {1'b0, i_div.divisor};
        n_div       = i_div;
        n_div.rem   = fits ? REM_W'(trial - {1'b0, i_div.divisor}) : trial[REM_W-1:0];
        n_div.num   = {i_div.num[NUM_W-2:0], 1'b0};
        n_div.quo   = {i_div.quo[NUM_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule
`default_nettype wire

[design/chiral_angle_force_2d.sv]
// Signed 2D harmonic angle force: one request per cycle while the output queue has room, fully pipelined.
// Stages: input stage, 4 prep stages, the CORDIC cell row,
// 4 force prep stages, 83 divider cells, output queue. Throughput one request per cycle,
// held off only when the two-entry output queue is full.
// Synchronous reset clears pipeline valids, the output queue and the type registers.
// Depends on caf_pkg, caf_cordic_cell, caf_div_cell.
`default_nettype none
module chiral_angle_force_2d #(
    parameter int CORDIC_STEPS = caf_pkg::DEFAULT_CORDIC_STEPS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [caf_pkg::POS_W-1:0] i_end_a_x,
    input  logic signed [caf_pkg::POS_W-1:0] i_end_a_y,
    input  logic signed [caf_pkg::POS_W-1:0] i_apex_x,
    input  logic signed [caf_pkg::POS_W-1:0] i_apex_y,
    input  logic signed [caf_pkg::POS_W-1:0] i_end_b_x,
    input  logic signed [caf_pkg::POS_W-1:0] i_end_b_y,
    input  logic [1:0]                      i_angle_type,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [caf_pkg::POS_W-1:0] o_force_a_x,
    output logic signed [caf_pkg::POS_W-1:0] o_force_a_y,
    output logic signed [caf_pkg::POS_W-1:0] o_force_apex_x,
    output logic signed [caf_pkg::POS_W-1:0] o_force_apex_y,
    output logic signed [caf_pkg::POS_W-1:0] o_force_b_x,
    output logic signed [caf_pkg::POS_W-1:0] o_force_b_y,
    output logic [caf_pkg::POS_W-1:0]       o_energy,
    output logic                            o_degenerate,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [caf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [caf_pkg::K_W-1:0]         i_cfg_data
);
    import caf_pkg::*;

    logic en;
    logic push;
    logic pop;

    logic [K_W-1:0]           r_spring [TYPES];
    logic signed [REST_W-1:0] r_rest   [TYPES];

    // stage A
    logic                     r_a_v;
    logic signed [DIF_W-1:0]  r_dx1, r_dy1, r_dx2, r_dy2;
    logic [K_W-1:0]           r_a_k;
    logic signed [REST_W-1:0] r_a_rest;
    // stage B
    logic                     r_b_v;
    logic signed [PROD_W-1:0] r_pxx, r_pyy, r_pxy, r_pyx;
    t_ctx                     r_b_ctx, n_b_ctx;
    logic [DIF_W-1:0]         ux1, uy1, ux2, uy2;
    // stage C
    logic                     r_c_v;
    logic signed [CS_W-1:0]   r_c, r_s;
    t_ctx                     r_c_ctx, n_c_ctx;
    // stage D
    logic                     r_d_v;
    logic [CS_W-1:0]          r_cm, r_sm;
    logic                     r_cn, r_sn;
    t_ctx                     r_d_ctx, n_d_ctx;
    // stage E
    logic                     r_e_v;
    t_vec                     r_e_vec, n_e_vec;
    t_ctx                     r_e_ctx;
    logic [CS_W-VIN_W-1:0]    hi;
    logic [2:0]               sh;
    logic [CS_W-1:0]          cm_sh, sm_sh;
    logic [VIN_W-1:0]         cms, sms;
    logic                     flip;
    // CORDIC row
    t_vec                     w_cin  [CORDIC_STEPS];
    t_vec                     w_cvec [CORDIC_STEPS];
    t_ctx                     r_cctx [CORDIC_STEPS];
    logic [CORDIC_STEPS-1:0]  r_cv;
    // stage F
    logic                     r_f_v;
    t_ctx                     r_f_ctx, n_f_ctx;
    logic [K_W-1:0]           r_f_dmag, n_f_dmag;
    logic signed [ANG_W-1:0]  theta;
    logic signed [ANG_W:0]    dth;
    // stage G
    logic                     r_g_v;
    t_ctx                     r_g_ctx;
    logic [2*K_W-1:0]         r_g_tk, r_g_dd;
    // stage H
    logic                     r_h_v;
    t_ctx                     r_h_ctx;
    logic [2*K_W-1:0]         r_h_elo, r_h_ehi;
    logic [PP_W-1:0]          r_h_plo [LANES];
    logic [PP_W-1:0]          r_h_phi [LANES];
    logic [MAG_W-1:0]         mulv    [LANES];
    // stage I
    logic                     r_i_v;
    t_tail                    r_i_tail, n_i_tail;
    t_div                     r_i_div [LANES];
    t_div                     n_i_div [LANES];
    logic [3*K_W-1:0]         e96;
    logic [NUM_W+12-1:0]      num95 [LANES];
    // divider rows
    t_div                     w_din [LANES][NUM_W];
    t_div                     w_div [LANES][NUM_W];
    t_tail                    r_dtail [NUM_W];
    logic [NUM_W-1:0]         r_dv;
    // output queue
    logic signed [F_W-1:0]    fw [LANES];
    logic signed [F_W-1:0]    fpx_w, fpy_w;
    t_res                     n_res;
    t_res                     r_q [2];
    logic [1:0]               r_cnt;
    logic                     r_wr, r_rd;

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [F_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (&v[F_W-1:POS_W-1] || ~|v[F_W-1:POS_W-1]) begin
            r = v[POS_W-1:0];
        end else if (v[F_W-1]) begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end
        return r;
    endfunction

    assign en          = (r_cnt != 2'd2);
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;
    assign push        = en && r_dv[NUM_W-1];
    assign pop         = o_out_valid && i_out_ready;

    // ---------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TYPES; t++) begin
                r_spring[t] <= '0;
                r_rest[t]   <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SPRING0: r_spring[0] <= i_cfg_data;
                REG_SPRING1: r_spring[1] <= i_cfg_data;
                REG_SPRING2: r_spring[2] <= i_cfg_data;
                REG_SPRING3: r_spring[3] <= i_cfg_data;
                REG_REST0:   r_rest[0]   <= i_cfg_data[REST_W-1:0];
                REG_REST1:   r_rest[1]   <= i_cfg_data[REST_W-1:0];
                REG_REST2:   r_rest[2]   <= i_cfg_data[REST_W-1:0];
                REG_REST3:   r_rest[3]   <= i_cfg_data[REST_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_cv  <= '0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
            r_i_v <= 1'b0;
            r_dv  <= '0;
        end else if (en) begin
            r_a_v <= i_in_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_cv  <= {r_cv[CORDIC_STEPS-2:0], r_e_v};
            r_f_v <= r_cv[CORDIC_STEPS-1];
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
            r_i_v <= r_h_v;
            r_dv  <= {r_dv[NUM_W-2:0], r_i_v};
        end
    end

    // ---------------- B: bond scaling for the force path
    always_comb begin
        ux1 = r_dx1[DIF_W-1] ? DIF_W'(-r_dx1) : DIF_W'(r_dx1);
        uy1 = r_dy1[DIF_W-1] ? DIF_W'(-r_dy1) : DIF_W'(r_dy1);
        ux2 = r_dx2[DIF_W-1] ? DIF_W'(-r_dx2) : DIF_W'(r_dx2);
        uy2 = r_dy2[DIF_W-1] ? DIF_W'(-r_dy2) : DIF_W'(r_dy2);
        n_b_ctx      = '0;
        n_b_ctx.k    = r_a_k;
        n_b_ctx.rest = r_a_rest;
        n_b_ctx.sdx1 = r_dx1[DIF_W-1];
        n_b_ctx.sdy1 = r_dy1[DIF_W-1];
        n_b_ctx.sdx2 = r_dx2[DIF_W-1];
        n_b_ctx.sdy2 = r_dy2[DIF_W-1];
        n_b_ctx.m1   = (ux1[DIF_W-1] | uy1[DIF_W-1]) ? 2'd2 :
                       (ux1[DIF_W-2] | uy1[DIF_W-2]) ? 2'd1 : 2'd0;
        n_b_ctx.m2   = (ux2[DIF_W-1] | uy2[DIF_W-1]) ? 2'd2 :
                       (ux2[DIF_W-2] | uy2[DIF_W-2]) ? 2'd1 : 2'd0;
        n_b_ctx.a1   = MAG_W'(ux1 >> n_b_ctx.m1);
        n_b_ctx.b1   = MAG_W'(uy1 >> n_b_ctx.m1);
        n_b_ctx.a2   = MAG_W'(ux2 >> n_b_ctx.m2);
        n_b_ctx.b2   = MAG_W'(uy2 >> n_b_ctx.m2);
    end

    // ---------------- C: squared bond lengths
    always_comb begin
        n_c_ctx      = r_b_ctx;
        n_c_ctx.r2_1 = REM_W'(62'(r_b_ctx.a1) * 62'(r_b_ctx.a1))
                     + REM_W'(62'(r_b_ctx.b1) * 62'(r_b_ctx.b1));
        n_c_ctx.r2_2 = REM_W'(62'(r_b_ctx.a2) * 62'(r_b_ctx.a2))
                     + REM_W'(62'(r_b_ctx.b2) * 62'(r_b_ctx.b2));
    end

    always_comb begin
        n_d_ctx       = r_c_ctx;
        n_d_ctx.degen = (r_c == '0) && (r_s == '0);
    end

    // ---------------- E: normalize into CORDIC range, fold left half-plane
    always_comb begin
        hi = r_cm[CS_W-1:VIN_W] | r_sm[CS_W-1:VIN_W];
        sh = 3'd0;
        for (int j = 0; j < CS_W - VIN_W; j++) begin
            if (hi[j]) begin
                sh = 3'(j + 1);
            end
        end
        cm_sh = r_cm >> sh;
        sm_sh = r_sm >> sh;
        cms   = cm_sh[VIN_W-1:0];
        sms   = sm_sh[VIN_W-1:0];
        flip  = r_cn && (cms != '0);
        n_e_vec.x = VEC_W'(cms);
        n_e_vec.y = (r_sn ^ flip) ? -VEC_W'(sms) : VEC_W'(sms);
        if (!flip) begin
            n_e_vec.z = '0;
        end else if (r_sn && (sms != '0)) begin
            n_e_vec.z = -PI_Q28;
        end else begin
            n_e_vec.z = PI_Q28;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx1    <= DIF_W'(i_end_a_x) - DIF_W'(i_apex_x);
            r_dy1    <= DIF_W'(i_end_a_y) - DIF_W'(i_apex_y);
            r_dx2    <= DIF_W'(i_end_b_x) - DIF_W'(i_apex_x);
            r_dy2    <= DIF_W'(i_end_b_y) - DIF_W'(i_apex_y);
            r_a_k    <= r_spring[i_angle_type];
            r_a_rest <= r_rest[i_angle_type];

            r_pxx   <= r_dx1 * r_dx2;
            r_pyy   <= r_dy1 * r_dy2;
            r_pxy   <= r_dx1 * r_dy2;
            r_pyx   <= r_dy1 * r_dx2;
            r_b_ctx <= n_b_ctx;

            r_c     <= -(CS_W'(r_pxx) + CS_W'(r_pyy));
            r_s     <= CS_W'(r_pxy) - CS_W'(r_pyx);
            r_c_ctx <= n_c_ctx;

            r_cm    <= r_c[CS_W-1] ? CS_W'(-r_c) : CS_W'(r_c);
            r_sm    <= r_s[CS_W-1] ? CS_W'(-r_s) : CS_W'(r_s);
            r_cn    <= r_c[CS_W-1];
            r_sn    <= r_s[CS_W-1];
            r_d_ctx <= n_d_ctx;

            r_e_vec <= n_e_vec;
            r_e_ctx <= r_d_ctx;

            r_cctx[0] <= r_e_ctx;
            for (int j = 1; j < CORDIC_STEPS; j++) begin
                r_cctx[j] <= r_cctx[j-1];
            end
        end
    end

    // ---------------- CORDIC cell row
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        if (g == 0) begin : g_head
            assign w_cin[g] = r_e_vec;
        end else begin : g_link
            assign w_cin[g] = w_cvec[g-1];
        end
        caf_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_vec (w_cin[g]),
            .o_vec (w_cvec[g])
        );
    end

    // ---------------- F: angle deviation
    always_comb begin
        theta    = r_cctx[CORDIC_STEPS-1].degen ? '0 : w_cvec[CORDIC_STEPS-1].z;
        dth      = (ANG_W+1)'(theta) - (ANG_W+1)'(r_cctx[CORDIC_STEPS-1].rest);
        n_f_dmag = dth[ANG_W] ? K_W'(-dth) : dth[K_W-1:0];
        n_f_ctx      = r_cctx[CORDIC_STEPS-1];
        n_f_ctx.tneg = dth[ANG_W];
    end

    always_comb begin
        mulv[0] = r_g_ctx.b1;
        mulv[1] = r_g_ctx.a1;
        mulv[2] = r_g_ctx.b2;
        mulv[3] = r_g_ctx.a2;
    end

    // ---------------- I: energy, numerators, divider setup
    always_comb begin
        e96 = {r_h_ehi, {K_W{1'b0}}} + (3*K_W)'(r_h_elo);
        n_i_tail.energy = (|e96[3*K_W-1:88]) ? {POS_W{1'b1}} : e96[87:56];
        n_i_tail.degen  = r_h_ctx.degen;
        n_i_tail.neg[0] = r_h_ctx.tneg ^ r_h_ctx.sdy1;
        n_i_tail.neg[1] = ~(r_h_ctx.tneg ^ r_h_ctx.sdx1);
        n_i_tail.neg[2] = ~(r_h_ctx.tneg ^ r_h_ctx.sdy2);
        n_i_tail.neg[3] = r_h_ctx.tneg ^ r_h_ctx.sdx2;
        for (int l = 0; l < LANES; l++) begin
            num95[l] = {r_h_phi[l], {K_W{1'b0}}} + (NUM_W+12)'(r_h_plo[l]);
            n_i_div[l].rem     = '0;
            n_i_div[l].quo     = '0;
            n_i_div[l].divisor = (l < 2) ? r_h_ctx.r2_1 : r_h_ctx.r2_2;
            n_i_div[l].num     = NUM_W'(num95[l] >>
                                 (4'd12 + {2'b00, (l < 2) ? r_h_ctx.m1 : r_h_ctx.m2}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_ctx  <= n_f_ctx;
            r_f_dmag <= n_f_dmag;

            r_g_ctx <= r_f_ctx;
            r_g_tk  <= r_f_ctx.k * r_f_dmag;
            r_g_dd  <= r_f_dmag * r_f_dmag;

            r_h_ctx <= r_g_ctx;
            r_h_elo <= r_g_ctx.k * r_g_dd[K_W-1:0];
            r_h_ehi <= r_g_ctx.k * r_g_dd[2*K_W-1:K_W];
            for (int l = 0; l < LANES; l++) begin
                r_h_plo[l] <= r_g_tk[K_W-1:0] * mulv[l];
                r_h_phi[l] <= r_g_tk[2*K_W-1:K_W] * mulv[l];
                r_i_div[l] <= n_i_div[l];
            end

            r_i_tail   <= n_i_tail;
            r_dtail[0] <= r_i_tail;
            for (int j = 1; j < NUM_W; j++) begin
                r_dtail[j] <= r_dtail[j-1];
            end
        end
    end

    // ---------------- divider cell rows, one per force component
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        for (genvar j = 0; j < NUM_W; j++) begin : g_div
            if (j == 0) begin : g_head
                assign w_din[l][j] = r_i_div[l];
            end else begin : g_link
                assign w_din[l][j] = w_div[l][j-1];
            end
            caf_div_cell u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_div (w_din[l][j]),
                .o_div (w_div[l][j])
            );
        end
    end

    // ---------------- final signs, apex balance, saturation
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            fw[l] = r_dtail[NUM_W-1].neg[l]
                  ? -$signed({{(F_W-NUM_W){1'b0}}, w_div[l][NUM_W-1].quo})
                  :  $signed({{(F_W-NUM_W){1'b0}}, w_div[l][NUM_W-1].quo});
        end
        fpx_w = -(fw[0] + fw[2]);
        fpy_w = -(fw[1] + fw[3]);
        n_res.energy = r_dtail[NUM_W-1].energy;
        n_res.degen  = r_dtail[NUM_W-1].degen;
        if (r_dtail[NUM_W-1].degen) begin
            n_res.fax = '0;
            n_res.fay = '0;
            n_res.fpx = '0;
            n_res.fpy = '0;
            n_res.fbx = '0;
            n_res.fby = '0;
        end else begin
            n_res.fax = sat32(fw[0]);
            n_res.fay = sat32(fw[1]);
            n_res.fpx = sat32(fpx_w);
            n_res.fpy = sat32(fpy_w);
            n_res.fbx = sat32(fw[2]);
            n_res.fby = sat32(fw[3]);
        end
    end

    // ---------------- two-entry output queue
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_out_valid    = (r_cnt != 2'd0);
    assign o_force_a_x    = r_q[r_rd].fax;
    assign o_force_a_y    = r_q[r_rd].fay;
    assign o_force_apex_x = r_q[r_rd].fpx;
    assign o_force_apex_y = r_q[r_rd].fpy;
    assign o_force_b_x    = r_q[r_rd].fbx;
    assign o_force_b_y    = r_q[r_rd].fby;
    assign o_energy       = r_q[r_rd].energy;
    assign o_degenerate   = r_q[r_rd].degen;

    // ---------------- assertions
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_degenerate |->
            o_force_a_x == '0 && o_force_a_y == '0 && o_force_apex_x == '0 &&
            o_force_apex_y == '0 && o_force_b_x == '0 && o_force_b_y == '0)
        else $error("degenerate result with nonzero force");

    a_queue_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("output queue count lost a request");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule
`default_nettype wire
